[rtl/core/wsar_pkg.sv]
// Shared types and constants for the weighted scatter-accumulate regrid block.
// Used by every module under rtl/core; has no dependencies of its own.

package wsar_pkg;

    // Default store depths.
    localparam int SRC_CELLS_DEF = 4096;
    localparam int DST_CELLS_DEF = 4096;

    // Field widths.
    localparam int IDX_W    = 12;   // width of src_index and dst_index
    localparam int CMP_W    = 17;   // wide enough to hold any store depth
    localparam int WORD_W   = 32;   // Q16.16 terms and Q4.28 weights
    localparam int ACC_W    = 48;   // Q32.16 accumulator
    localparam int PROD_W   = 64;   // exact term times weight
    localparam int FRAC_W   = 28;   // weight fraction bits dropped by the shift
    localparam int SHIFT_W  = PROD_W - FRAC_W;
    localparam int PSUM_W   = SHIFT_W + 2;
    localparam int SUM_W    = ACC_W + 2;
    localparam int TERMS    = 4;
    localparam int SRC_W    = TERMS * WORD_W;
    localparam int S_DATA_W = 280;
    localparam int M_DATA_W = 48;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_SRC_WR = 2'd0,
        OP_DST_WR = 2'd1,
        OP_LINK   = 2'd2,
        OP_DST_RD = 2'd3
    } wsar_op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ACC
    } wsar_state_t;

    // Control from the sequencer to the link arithmetic.
    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic src_ok;
        logic use_grad;
        logic use_cross;
    } wsar_alu_ctrl_t;

endpackage

[rtl/core/wsar_src_mem.sv]
// Source cell store: value and three gradients per cell in one wide memory.
// Depends on wsar_pkg for the word widths.

module wsar_src_mem #(
    parameter int CELLS = wsar_pkg::SRC_CELLS_DEF,
    parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [AW-1:0]            addr,
    input  logic [wsar_pkg::SRC_W-1:0] wr_data,
    output logic [wsar_pkg::SRC_W-1:0] rd_data
);

    logic [wsar_pkg::SRC_W-1:0] mem [CELLS];
    logic [wsar_pkg::SRC_W-1:0] rd_data_reg;

    // Single port: a cell is loaded or read through the one shared address.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/wsar_dst_mem.sv]
// Destination accumulator store with a clearing sweep after reset.
// Depends on wsar_pkg for the accumulator width.

module wsar_dst_mem #(
    parameter int CELLS = wsar_pkg::DST_CELLS_DEF,
    parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [wsar_pkg::ACC_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [wsar_pkg::ACC_W-1:0] wr_data,
    output logic                      clr_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    logic [wsar_pkg::ACC_W-1:0] mem [CELLS];
    logic [wsar_pkg::ACC_W-1:0] rd_data_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic [AW-1:0]              clr_cnt_next;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;

    // Sweep counter: one entry cleared per cycle until the last one.
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // The sweep owns the write port while it runs.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

[rtl/core/wsar_link_alu.sv]
// Link arithmetic: four term-by-weight products, their floored sum, and the
// saturating add into the accumulator. Depends on wsar_pkg.

module wsar_link_alu (
    input  logic                              aclk,
    input  wsar_pkg::wsar_alu_ctrl_t          ctrl,
    input  logic [wsar_pkg::SRC_W-1:0]        terms,
    input  logic [wsar_pkg::SRC_W-1:0]        weights,
    input  logic signed [wsar_pkg::ACC_W-1:0] acc_in,
    output logic signed [wsar_pkg::ACC_W-1:0] acc_out,
    output logic                              sat
);

    localparam int TERMS  = wsar_pkg::TERMS;
    localparam int WORD_W = wsar_pkg::WORD_W;

    logic signed [wsar_pkg::PROD_W-1:0] prod_reg [TERMS];
    logic signed [wsar_pkg::PSUM_W-1:0] psum_reg;
    logic signed [wsar_pkg::PSUM_W-1:0] psum_next;
    logic signed [wsar_pkg::PSUM_W-1:0] lane_sel [TERMS];
    logic [TERMS-1:0]                   lane_use;
    logic signed [wsar_pkg::SUM_W-1:0]  total;

    // Products, one multiplier per term, registered.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            for (int i = 0; i < TERMS; i++) begin
                prod_reg[i] <= $signed(terms[i*WORD_W +: WORD_W])
                             * $signed(weights[i*WORD_W +: WORD_W]);
            end
        end
    end

    // Order selects the lanes: value always, lat and lon, then cross; all are off for an out-of-range source.
    assign lane_use = {ctrl.use_cross, ctrl.use_grad, ctrl.use_grad, 1'b1}
                    & {TERMS{ctrl.src_ok}};

    // The arithmetic shift of each product floors it to Q20.16.
    always_comb begin
        psum_next = '0;
        for (int i = 0; i < TERMS; i++) begin
            lane_sel[i] = lane_use[i]
                ? wsar_pkg::PSUM_W'($signed(prod_reg[i][wsar_pkg::PROD_W-1:wsar_pkg::FRAC_W]))
                : '0;
            psum_next = psum_next + lane_sel[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            psum_reg <= psum_next;
        end
    end

    // Exact add, then one clip to the accumulator range.
    assign total = wsar_pkg::SUM_W'(acc_in) + wsar_pkg::SUM_W'(psum_reg);

    always_comb begin
        sat     = (total[wsar_pkg::SUM_W-1:wsar_pkg::ACC_W-1] != '0)
               && (total[wsar_pkg::SUM_W-1:wsar_pkg::ACC_W-1] != '1);
        acc_out = total[wsar_pkg::ACC_W-1:0];
        if (sat) begin
            acc_out = total[wsar_pkg::SUM_W-1]
                ? {1'b1, {(wsar_pkg::ACC_W-1){1'b0}}}
                : {1'b0, {(wsar_pkg::ACC_W-1){1'b1}}};
        end
    end

endmodule

[rtl/core/weighted_scatter_accumulate_regrid.sv]
// Top level of the weighted scatter-accumulate regrid block: sequencer, item
// registers and output register. Depends on wsar_pkg, wsar_src_mem,
// wsar_dst_mem and wsar_link_alu.
//
// Usage:
//   The s_ channel carries one op per transfer: op in s_tuser, indices, cell
//   words and link weights in s_tdata. Every op returns exactly one transfer
//   on the m_ channel: the destination accumulator in m_tdata (zero for a
//   source write or an out-of-range destination) and the clip flag of a link
//   in m_tuser. cfg_wr_en with cfg_wr_data sets the remap order; write it only
//   while the block is idle.
//   Each op passes a memory read, a multiply step, a sum step and a write-back
//   step, each registered; a new op is taken only once the write-back is done
//   and the sequencer is back in idle, as the read-modify-write of the
//   destination memory needs it: the write finishes before the next op reads,
//   so back-to-back links to one cell need no forwarding.
//   After reset the destination memory is cleared one entry a cycle; s_tready
//   stays low meanwhile and config writes are still taken. Source cells hold
//   no defined value until written.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next op and waits in its write-back cycle until the
//   output register is free.

module weighted_scatter_accumulate_regrid #(
    parameter int SRC_CELLS = wsar_pkg::SRC_CELLS_DEF,
    parameter int DST_CELLS = wsar_pkg::DST_CELLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: src_index, dst_index, cell_value, grad_lat, grad_lon,
    // grad_cross, w_value, w_lat, w_lon, w_cross.
    input  logic [wsar_pkg::S_DATA_W-1:0]   s_tdata,
    // From bit 0: op.
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: read_data.
    output logic [wsar_pkg::M_DATA_W-1:0]   m_tdata,
    // From bit 0: saturated.
    output logic                            m_tuser
);

    localparam int SRC_AW = (SRC_CELLS > 1) ? $clog2(SRC_CELLS) : 1;
    localparam int DST_AW = (DST_CELLS > 1) ? $clog2(DST_CELLS) : 1;
    localparam int IDX_W  = wsar_pkg::IDX_W;
    localparam int CMP_W  = wsar_pkg::CMP_W;
    localparam int WORD_W = wsar_pkg::WORD_W;
    localparam int ACC_W  = wsar_pkg::ACC_W;

    // Input field unpacking.
    logic [IDX_W-1:0]           in_src_index;
    logic [IDX_W-1:0]           in_dst_index;
    logic [wsar_pkg::SRC_W-1:0] in_src_words;
    logic [wsar_pkg::SRC_W-1:0] in_weights;
    logic                       in_src_ok;
    logic                       in_dst_ok;
    logic                       s_accept;

    assign in_src_index = s_tdata[IDX_W-1:0];
    assign in_dst_index = s_tdata[2*IDX_W-1:IDX_W];
    assign in_src_words = s_tdata[2*IDX_W +: wsar_pkg::SRC_W];
    assign in_weights   = s_tdata[2*IDX_W + wsar_pkg::SRC_W +: wsar_pkg::SRC_W];
    assign in_src_ok    = CMP_W'(in_src_index) < CMP_W'(SRC_CELLS);
    assign in_dst_ok    = CMP_W'(in_dst_index) < CMP_W'(DST_CELLS);
    assign s_accept     = s_tvalid && s_tready;

    // Configuration register.
    logic [1:0] order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= '0;
        end else if (cfg_wr_en) begin
            order_reg <= cfg_wr_data;
        end
    end

    // Item registers, loaded at the input transfer.
    wsar_pkg::wsar_op_t         op_reg;
    logic                       src_ok_reg;
    logic                       dst_ok_reg;
    logic [DST_AW-1:0]          dst_addr_reg;
    logic signed [WORD_W-1:0]   cell_reg;
    logic [wsar_pkg::SRC_W-1:0] weights_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= wsar_pkg::wsar_op_t'(s_tuser);
            src_ok_reg   <= in_src_ok;
            dst_ok_reg   <= in_dst_ok;
            dst_addr_reg <= DST_AW'(in_dst_index);
            cell_reg     <= $signed(in_src_words[WORD_W-1:0]);
            weights_reg  <= in_weights;
        end
    end

    // Stores and link arithmetic.
    logic [wsar_pkg::SRC_W-1:0] src_rd_data;
    logic [ACC_W-1:0]           dst_rd_data;
    logic                       dst_wr_en;
    logic [ACC_W-1:0]           dst_wr_data;
    logic                       clr_busy;
    wsar_pkg::wsar_alu_ctrl_t   alu_ctrl;
    logic signed [ACC_W-1:0]    alu_acc;
    logic                       alu_sat;

    wsar_src_mem #(
        .CELLS (SRC_CELLS),
        .AW    (SRC_AW)
    ) u_src_mem (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_tuser == wsar_pkg::OP_SRC_WR) && in_src_ok),
        .rd_en   (s_accept && (s_tuser == wsar_pkg::OP_LINK) && in_src_ok),
        .addr    (SRC_AW'(in_src_index)),
        .wr_data (in_src_words),
        .rd_data (src_rd_data)
    );

    wsar_dst_mem #(
        .CELLS (DST_CELLS),
        .AW    (DST_AW)
    ) u_dst_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept && in_dst_ok),
        .rd_addr  (DST_AW'(in_dst_index)),
        .rd_data  (dst_rd_data),
        .wr_en    (dst_wr_en),
        .wr_addr  (dst_addr_reg),
        .wr_data  (dst_wr_data),
        .clr_busy (clr_busy)
    );

    wsar_link_alu u_link_alu (
        .aclk    (aclk),
        .ctrl    (alu_ctrl),
        .terms   (src_rd_data),
        .weights (weights_reg),
        .acc_in  ($signed(dst_rd_data)),
        .acc_out (alu_acc),
        .sat     (alu_sat)
    );

    // Output register.
    logic                m_tvalid_reg;
    logic [ACC_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;

    // Sequencer state.
    wsar_pkg::wsar_state_t state_reg;
    wsar_pkg::wsar_state_t state_next;
    logic                  out_free;
    logic                  finish;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsar_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = wsar_pkg::ST_MUL;
                end
            end
            wsar_pkg::ST_MUL: state_next = wsar_pkg::ST_SUM;
            wsar_pkg::ST_SUM: state_next = wsar_pkg::ST_ACC;
            wsar_pkg::ST_ACC: begin
                if (out_free) begin
                    state_next = wsar_pkg::ST_IDLE;
                end
            end
            default: state_next = wsar_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsar_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer outputs and the result of the current op.
    logic [ACC_W-1:0] result_data;
    logic             result_sat;

    always_comb begin
        s_tready           = (state_reg == wsar_pkg::ST_IDLE) && !clr_busy;
        alu_ctrl.mul_en    = (state_reg == wsar_pkg::ST_MUL);
        alu_ctrl.sum_en    = (state_reg == wsar_pkg::ST_SUM);
        alu_ctrl.src_ok    = src_ok_reg;
        alu_ctrl.use_grad  = (order_reg != 2'd0);
        alu_ctrl.use_cross = order_reg[1];
        finish             = (state_reg == wsar_pkg::ST_ACC) && out_free;

        result_data = '0;
        result_sat  = 1'b0;
        if (dst_ok_reg) begin
            case (op_reg)
                wsar_pkg::OP_DST_WR: result_data = ACC_W'(cell_reg);
                wsar_pkg::OP_LINK: begin
                    result_data = alu_acc;
                    result_sat  = alu_sat;
                end
                wsar_pkg::OP_DST_RD: result_data = dst_rd_data;
                default:             result_data = '0;
            endcase
        end

        dst_wr_en   = finish && dst_ok_reg
                   && ((op_reg == wsar_pkg::OP_DST_WR) || (op_reg == wsar_pkg::OP_LINK));
        dst_wr_data = result_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= result_data;
            m_tuser_reg <= result_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // No op is taken while the destination memory is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !clr_busy)
        else $error("input transfer during destination clear");

    // An accepted op always moves on to the multiply cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == wsar_pkg::ST_MUL))
        else $error("accepted op did not start");

    // Only a link can report a clip.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && result_sat) |-> (op_reg == wsar_pkg::OP_LINK))
        else $error("clip flag on an op other than a link");

    // A finished result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("waiting result overwritten");

endmodule

[tb/wsar_tb_pkg.sv]
`timescale 1ns / 100ps
// Remap order codes shared by the regrid testbench top and its checker.
// Has no dependencies.

package wsar_tb_pkg;

    // Values of the remap order register.
    typedef enum logic [1:0] {
        ORDER_VALUE = 2'd0,
        ORDER_GRAD  = 2'd1,
        ORDER_FULL  = 2'd2,
        ORDER_ALIAS = 2'd3
    } remap_order_t;

endpackage

[tb/wsar_checker.sv]
`timescale 1ns / 100ps
// Checker for the weighted scatter-accumulate regrid block: watches both streams,
// predicts each accumulator result and compares. Depends on wsar_pkg and wsar_tb_pkg.

module wsar_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [wsar_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wsar_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    output int                              pending,
    output int                              mismatches
);

    localparam int     ACC_W      = wsar_pkg::ACC_W;
    localparam int     WORD_W     = wsar_pkg::WORD_W;
    localparam int     IDX_W      = wsar_pkg::IDX_W;
    localparam int     FRAC_W     = wsar_pkg::FRAC_W;
    localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_W - 1));
    localparam int     PRINT_CAP  = 200;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             sat;
    } acc_result_t;

    // Shadow copies of the source terms and destination accumulators.
    logic signed [WORD_W-1:0]  src_value [wsar_pkg::SRC_CELLS_DEF];
    logic signed [WORD_W-1:0]  src_lat   [wsar_pkg::SRC_CELLS_DEF];
    logic signed [WORD_W-1:0]  src_lon   [wsar_pkg::SRC_CELLS_DEF];
    logic signed [WORD_W-1:0]  src_cross [wsar_pkg::SRC_CELLS_DEF];
    logic signed [ACC_W-1:0]   dst_acc   [wsar_pkg::DST_CELLS_DEF];
    wsar_tb_pkg::remap_order_t order;
    acc_result_t               acc_expect_q [$];
    int unsigned               result_no;

    // Q16.16 term times Q4.28 weight, floored back to Q32.16.
    function automatic longint scaled_product(logic signed [WORD_W-1:0] term,
                                              logic signed [WORD_W-1:0] weight);
        longint p;
        p = longint'(term) * longint'(weight);
        return p >>> FRAC_W;
    endfunction

    // Apply one op to the shadow stores and return the result it produces.
    function automatic acc_result_t predict_cell_op(wsar_pkg::wsar_op_t op,
                                                    logic [wsar_pkg::S_DATA_W-1:0] d);
        logic [IDX_W-1:0]         si;
        logic [IDX_W-1:0]         di;
        logic signed [WORD_W-1:0] cell_word;
        longint                   sum;
        acc_result_t              res;
        si        = d[11:0];
        di        = d[23:12];
        cell_word = d[55:24];
        res       = '0;
        case (op)
            wsar_pkg::OP_SRC_WR: begin
                src_value[si] = cell_word;
                src_lat[si]   = d[87:56];
                src_lon[si]   = d[119:88];
                src_cross[si] = d[151:120];
            end
            wsar_pkg::OP_DST_WR: begin
                dst_acc[di] = ACC_W'(cell_word);
                res.acc     = dst_acc[di];
            end
            wsar_pkg::OP_LINK: begin
                // Exact sum of the old value and all used products, clipped once.
                sum = longint'(dst_acc[di]);
                sum += scaled_product(src_value[si], d[183:152]);
                if (order != wsar_tb_pkg::ORDER_VALUE) begin
                    sum += scaled_product(src_lat[si], d[215:184]);
                    sum += scaled_product(src_lon[si], d[247:216]);
                end
                if (order == wsar_tb_pkg::ORDER_FULL || order == wsar_tb_pkg::ORDER_ALIAS) begin
                    sum += scaled_product(src_cross[si], d[279:248]);
                end
                if (sum > ACC_TOP) begin
                    sum     = ACC_TOP;
                    res.sat = 1'b1;
                end else if (sum < ACC_BOTTOM) begin
                    sum     = ACC_BOTTOM;
                    res.sat = 1'b1;
                end
                dst_acc[di] = sum[ACC_W-1:0];
                res.acc     = dst_acc[di];
            end
            default: begin
                res.acc = dst_acc[di];
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("wsar_checker: result %0d: %s: got %h, expected %h",
                     result_no, what, got, want);
        end
    endtask

    // Sample both channels at the rising edge; results are checked before the
    // input transfer of the same edge is predicted.
    always @(posedge aclk) begin : monitor
        acc_result_t want;
        if (!aresetn) begin
            foreach (dst_acc[i]) dst_acc[i] = '0;
            order = wsar_tb_pkg::ORDER_VALUE;
            acc_expect_q.delete();
            result_no  = 0;
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                order = wsar_tb_pkg::remap_order_t'(cfg_wr_data);
            end
            if (m_tvalid && m_tready) begin
                if (acc_expect_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(m_tdata), '0);
                end else begin
                    want = acc_expect_q.pop_front();
                    if (m_tdata !== want.acc) begin
                        report_mismatch("read_data", 64'(m_tdata), 64'(want.acc));
                    end
                    if (m_tuser !== want.sat) begin
                        report_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                acc_expect_q.push_back(
                    predict_cell_op(wsar_pkg::wsar_op_t'(s_tuser), s_tdata));
            end
        end
        pending <= acc_expect_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for weighted_scatter_accumulate_regrid: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on wsar_pkg, wsar_tb_pkg and wsar_checker.

module tb_top;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          PHASE_ITEMS    = 186;
    localparam int          PILE_LINKS     = 8;
    localparam logic [31:0] W_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN          = 32'h8000_0000;
    localparam logic [31:0] ONE_Q428       = 32'h1000_0000;
    localparam logic [31:0] NEG_ONE_Q428   = 32'hF000_0000;
    // Remap order of each random phase, first phase in the low bits.
    localparam logic [9:0]  PHASE_ORDERS   = {wsar_tb_pkg::ORDER_FULL,
                                              wsar_tb_pkg::ORDER_ALIAS,
                                              wsar_tb_pkg::ORDER_VALUE,
                                              wsar_tb_pkg::ORDER_FULL,
                                              wsar_tb_pkg::ORDER_GRAD};

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [1:0]                      cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [wsar_pkg::S_DATA_W-1:0]   s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [wsar_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    int                              pending;
    int                              mismatches;
    bit                              gaps_on;
    bit                              hold_req;
    bit                              src_loaded [wsar_pkg::SRC_CELLS_DEF];
    int unsigned                     loaded_q [$];

    weighted_scatter_accumulate_regrid u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    wsar_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly random words, with the extremes mixed in.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Indexes favor a few hot cells so links pile onto the same accumulators.
    function automatic logic [11:0] pick_index();
        if ($urandom_range(0, 9) < 7) return 12'($urandom_range(0, 15));
        return 12'($urandom_range(0, wsar_pkg::SRC_CELLS_DEF - 1));
    endfunction

    // Offer one transfer and hold it until accepted, then maybe leave a gap.
    task automatic send_item(wsar_pkg::wsar_op_t op, logic [11:0] si, logic [11:0] di,
                             logic [31:0] cell_word, logic [31:0] g_lat, logic [31:0] g_lon,
                             logic [31:0] g_cross, logic [31:0] w_v, logic [31:0] w_la,
                             logic [31:0] w_lo, logic [31:0] w_cr);
        int unsigned gap;
        @(negedge aclk);
        s_tuser  = op;
        s_tdata  = {w_cr, w_lo, w_la, w_v, g_cross, g_lon, g_lat, cell_word, di, si};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic load_source(logic [11:0] si, logic [31:0] v, logic [31:0] g_lat,
                               logic [31:0] g_lon, logic [31:0] g_cross);
        send_item(wsar_pkg::OP_SRC_WR, si, 12'($urandom), v, g_lat, g_lon, g_cross,
                  $urandom, $urandom, $urandom, $urandom);
        if (!src_loaded[si]) begin
            src_loaded[si] = 1'b1;
            loaded_q.push_back(si);
        end
    endtask

    task automatic preset_dest(logic [11:0] di, logic [31:0] v);
        send_item(wsar_pkg::OP_DST_WR, 12'($urandom), di, v, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic apply_link(logic [11:0] si, logic [11:0] di, logic [31:0] w_v,
                              logic [31:0] w_la, logic [31:0] w_lo, logic [31:0] w_cr);
        send_item(wsar_pkg::OP_LINK, si, di, $urandom, $urandom, $urandom, $urandom,
                  w_v, w_la, w_lo, w_cr);
    endtask

    task automatic read_dest(logic [11:0] di);
        send_item(wsar_pkg::OP_DST_RD, 12'($urandom), di, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Links only ever read source cells that have been loaded.
    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            load_source(pick_index(), rand_word(), rand_word(), rand_word(), rand_word());
        end else if (pick < 30) begin
            preset_dest(pick_index(), rand_word());
        end else if (pick < 85) begin
            apply_link(12'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]), pick_index(),
                       rand_word(), rand_word(), rand_word(), rand_word());
        end else begin
            read_dest(pick_index());
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_order(wsar_tb_pkg::remap_order_t value);
        drain();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_tready  = 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = wsar_pkg::OP_SRC_WR;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = wsar_tb_pkg::ORDER_VALUE;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme cells and weights, floor rounding, unused terms ignored.
        write_order(wsar_tb_pkg::ORDER_VALUE);
        load_source(12'd0, W_MAX, W_MIN, W_MAX, W_MIN);
        load_source(12'd4095, W_MIN, W_MAX, W_MIN, W_MAX);
        read_dest(12'd100);
        preset_dest(12'd0, W_MAX);
        preset_dest(12'd4095, W_MIN);
        apply_link(12'd0, 12'd0, W_MAX, W_MAX, W_MAX, W_MAX);
        apply_link(12'd4095, 12'd4095, W_MIN, W_MIN, W_MIN, W_MIN);
        apply_link(12'd4095, 12'd0, W_MAX, '0, '0, '0);
        load_source(12'd1, '1, 32'd1, '1, 32'd1);
        apply_link(12'd1, 12'd5, 32'd1, 32'd1, 32'd1, 32'd1);
        read_dest(12'd5);
        read_dest(12'd0);
        read_dest(12'd4095);

        write_order(wsar_tb_pkg::ORDER_GRAD);
        apply_link(12'd0, 12'd0, ONE_Q428, ONE_Q428, NEG_ONE_Q428, W_MAX);
        apply_link(12'd1, 12'd5, ONE_Q428, W_MIN, W_MAX, W_MAX);
        read_dest(12'd0);

        write_order(wsar_tb_pkg::ORDER_FULL);
        apply_link(12'd4095, 12'd4095, W_MIN, W_MIN, W_MIN, W_MIN);
        apply_link(12'd1, 12'd5, ONE_Q428, ONE_Q428, ONE_Q428, NEG_ONE_Q428);

        // Order three uses all four terms; pile the largest products onto two
        // accumulators, one in each direction.
        write_order(wsar_tb_pkg::ORDER_ALIAS);
        apply_link(12'd0, 12'd7, ONE_Q428, ONE_Q428, ONE_Q428, ONE_Q428);
        read_dest(12'd7);
        load_source(12'd2, W_MIN, W_MIN, W_MIN, W_MIN);
        preset_dest(12'd9, '0);
        repeat (PILE_LINKS) apply_link(12'd2, 12'd9, W_MIN, W_MIN, W_MIN, W_MIN);
        preset_dest(12'd10, '0);
        repeat (PILE_LINKS) apply_link(12'd2, 12'd10, W_MAX, W_MAX, W_MAX, W_MAX);
        read_dest(12'd10);

        // Random phases, one remap order each; the last runs without gaps.
        for (int ph = 0; ph < 5; ph++) begin
            write_order(wsar_tb_pkg::remap_order_t'(PHASE_ORDERS[2*ph +: 2]));
            if (ph == 1) hold_req = 1'b1;
            if (ph == 4) gaps_on = 1'b0;
            repeat (PHASE_ITEMS) random_item();
        end
        drain();

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
